// ===== design/bbpa_pkg.sv =====
`default_nettype none

package bbpa_pkg;

    localparam int ADDR_W     = 32;
    localparam int PAGES_W    = 7;
    localparam int BSL2_W     = 5;
    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int FREED_W    = 7;
    localparam int FREEBUF_W  = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_W      = 56;

    // allocation bitmap is kept as words; one word is read per cycle
    localparam int WORD_W = 16;

    localparam logic [PAGES_W-1:0] CFG_PAGES_RST = 7'd64;
    localparam logic [BSL2_W-1:0]  CFG_BSL2_RST  = 5'd10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TRIM  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_NO_BUF   = 2'd2,
        ST_BAD_ADDR = 2'd3
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_POOL_ENABLED = 2'd0,
        REG_POOL_BASE    = 2'd1,
        REG_POOL_PAGES   = 2'd2,
        REG_BUF_SIZE_L2  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_SET,
        S_ALLOC_MAP,
        S_FREE_CHK,
        S_TRIM,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_START,
        DP_DISABLED,
        DP_ALLOC_FIND,
        DP_ALLOC_SET,
        DP_ALLOC_MAP,
        DP_FREE_SUB,
        DP_FREE_CHK,
        DP_TRIM_INIT,
        DP_TRIM_STEP,
        DP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        op_t  opcode;
        logic enabled;
        logic trim_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/bbpa_datapath.sv =====
`default_nettype none

module bbpa_datapath #(
    parameter int MAX_BUFFERS    = 256,
    parameter int MAX_PAGES      = 64,
    parameter int PAGE_SIZE_LOG2 = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wen,
    input  wire logic [bbpa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bbpa_pkg::ADDR_W-1:0]         cfg_wdata,
    input  wire logic [bbpa_pkg::ADDR_W-1:0]         in_address,
    input  wire logic [bbpa_pkg::OPCODE_W-1:0]       in_opcode,
    input  wire bbpa_pkg::dp_cmd_t                   cmd,
    output bbpa_pkg::dp_status_t                     stat,
    output logic [bbpa_pkg::OUT_W-1:0]               out_tdata
);

    localparam int WORD_W  = bbpa_pkg::WORD_W;
    localparam int WB_W    = $clog2(WORD_W);
    localparam int NW      = (MAX_BUFFERS + WORD_W - 1) / WORD_W;
    localparam int WA_W    = (NW > 1) ? $clog2(NW) : 1;
    localparam int BIT_W   = WA_W + WB_W;
    localparam int NBUF_W  = $clog2(MAX_BUFFERS + 1);
    localparam int PG_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
    localparam int CNT_MAX = (MAX_BUFFERS > MAX_PAGES) ? MAX_BUFFERS : MAX_PAGES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int ADDR_W  = bbpa_pkg::ADDR_W;
    localparam int PAGES_W = bbpa_pkg::PAGES_W;
    localparam int BSL2_W  = bbpa_pkg::BSL2_W;
    localparam int BYTES_W = PAGES_W + PAGE_SIZE_LOG2;
    localparam int OFF_W   = BIT_W + ADDR_W;

    // buffers in the pool: page bytes over buffer size, capped
    function automatic logic [NBUF_W-1:0] buf_total(
        input logic [PAGES_W-1:0] pages,
        input logic [BSL2_W-1:0]  bsl2
    );
        logic [PAGES_W-1:0] eff;
        logic [BYTES_W-1:0] pool_bytes;
        logic [BYTES_W-1:0] cnt;
        eff = (11'(pages) > 11'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES) : pages;
        pool_bytes = BYTES_W'(eff) << PAGE_SIZE_LOG2;
        cnt = pool_bytes >> bsl2;
        buf_total = (cnt > BYTES_W'(MAX_BUFFERS)) ? NBUF_W'(MAX_BUFFERS) : NBUF_W'(cnt);
    endfunction

    localparam logic [NBUF_W-1:0] RESET_NBUF =
        buf_total(bbpa_pkg::CFG_PAGES_RST, bbpa_pkg::CFG_BSL2_RST);

    // configuration
    logic                 enable_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [PAGES_W-1:0]   pages_reg;
    logic [BSL2_W-1:0]    bsl2_reg;

    // store
    logic [WORD_W-1:0]    words_reg [NW];
    logic [MAX_PAGES-1:0] mapped_reg;
    logic [NBUF_W-1:0]    free_cnt_reg;

    // per-transaction working registers
    bbpa_pkg::op_t        op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    off_reg;
    logic [WA_W-1:0]      widx_reg;
    logic                 found_reg;
    logic [BIT_W-1:0]     n_reg;
    logic                 ok_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 clean_reg;
    logic [ADDR_W-1:0]    res_addr_reg;
    bbpa_pkg::status_t    res_status_reg;
    logic [PCNT_W-1:0]    freed_reg;
    logic [bbpa_pkg::OUT_W-1:0] out_tdata_reg;

    logic [NBUF_W-1:0]    nbuf;
    logic [PAGES_W-1:0]   cfg_pages_new;
    logic [BSL2_W-1:0]    cfg_bsl2_new;
    logic [NBUF_W-1:0]    cfg_nbuf;

    logic                 alloc_found;
    logic [WA_W-1:0]      alloc_widx;
    logic [BIT_W-1:0]     rd_n;
    logic [WORD_W-1:0]    rd_word;
    logic                 rd_bit;
    logic [WB_W-1:0]      zero_b;
    logic [BIT_W-1:0]     alloc_n;
    logic                 alloc_ok;
    logic [OFF_W-1:0]     alloc_off;
    logic [OFF_W-1:0]     alloc_page;
    logic                 alloc_page_ok;

    logic [ADDR_W-1:0]    free_n;
    logic                 free_misalign;
    logic                 free_ok;

    logic                 big_mode;
    logic [BSL2_W-1:0]    sh_big;
    logic [BSL2_W-1:0]    sh_small;
    logic [CNT_W-1:0]     buf_idx;
    logic [CNT_W-1:0]     small_page;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W-1:0]     grp_mask;
    logic                 grp_end;
    logic                 clean_now;
    logic                 trim_valid;
    logic                 trim_hit;
    logic [PG_W-1:0]      trim_page;

    assign nbuf = buf_total(pages_reg, bsl2_reg);

    assign cfg_pages_new = (bbpa_pkg::reg_idx_t'(cfg_addr) == bbpa_pkg::REG_POOL_PAGES)
                         ? cfg_wdata[PAGES_W-1:0] : pages_reg;
    assign cfg_bsl2_new  = (bbpa_pkg::reg_idx_t'(cfg_addr) == bbpa_pkg::REG_BUF_SIZE_L2)
                         ? cfg_wdata[BSL2_W-1:0] : bsl2_reg;
    assign cfg_nbuf      = buf_total(cfg_pages_new, cfg_bsl2_new);

    // lowest word that still has a clear bit
    always_comb
    begin
        alloc_found = 1'b0;
        alloc_widx  = '0;
        for (int w = NW - 1; w >= 0; w--)
        begin
            if (!(&words_reg[w]))
            begin
                alloc_found = 1'b1;
                alloc_widx  = WA_W'(w);
            end
        end
    end

    // trim walk
    assign big_mode   = (bsl2_reg >= BSL2_W'(PAGE_SIZE_LOG2));
    assign sh_big     = bsl2_reg - BSL2_W'(PAGE_SIZE_LOG2);
    assign sh_small   = BSL2_W'(PAGE_SIZE_LOG2) - bsl2_reg;
    assign buf_idx    = cnt_reg >> sh_big;
    assign small_page = cnt_reg >> sh_small;
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign grp_mask   = ~({CNT_W{1'b1}} << sh_small);
    assign trim_valid = big_mode ? (cnt_reg < CNT_W'(MAX_PAGES)) : (cnt_reg < CNT_W'(nbuf));

    // free address check
    assign free_n        = off_reg >> bsl2_reg;
    assign free_misalign = |(off_reg & ~({ADDR_W{1'b1}} << bsl2_reg));

    // single read port into the bitmap words
    always_comb
    begin
        unique case (cmd.op)
            bbpa_pkg::DP_ALLOC_SET: rd_n = {widx_reg, {WB_W{1'b0}}};
            bbpa_pkg::DP_FREE_CHK:  rd_n = BIT_W'(free_n);
            bbpa_pkg::DP_TRIM_STEP: rd_n = big_mode ? BIT_W'(buf_idx) : BIT_W'(cnt_reg);
            default:                rd_n = '0;
        endcase
    end

    assign rd_word = words_reg[rd_n[BIT_W-1:WB_W]];
    assign rd_bit  = rd_word[rd_n[WB_W-1:0]];

    always_comb
    begin
        zero_b = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (!rd_word[b])
            begin
                zero_b = WB_W'(b);
            end
        end
    end

    assign alloc_n  = {widx_reg, zero_b};
    assign alloc_ok = found_reg && (free_cnt_reg != '0) && (alloc_n < nbuf);

    assign alloc_off     = OFF_W'(n_reg) << bsl2_reg;
    assign alloc_page    = alloc_off >> PAGE_SIZE_LOG2;
    assign alloc_page_ok = (alloc_page < OFF_W'(MAX_PAGES));

    assign free_ok = !free_misalign && (free_n < ADDR_W'(nbuf)) && rd_bit;

    assign clean_now = clean_reg && !rd_bit;
    assign grp_end   = ((cnt_reg & grp_mask) == grp_mask) || (cnt_inc == CNT_W'(nbuf));

    always_comb
    begin
        if (big_mode)
        begin
            trim_page = cnt_reg[PG_W-1:0];
            trim_hit  = trim_valid && (buf_idx < nbuf) && !rd_bit
                        && mapped_reg[cnt_reg[PG_W-1:0]];
        end
        else
        begin
            trim_page = small_page[PG_W-1:0];
            trim_hit  = trim_valid && grp_end && clean_now
                        && (small_page < CNT_W'(MAX_PAGES))
                        && mapped_reg[small_page[PG_W-1:0]];
        end
    end

    // configuration and store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            base_reg     <= '0;
            pages_reg    <= bbpa_pkg::CFG_PAGES_RST;
            bsl2_reg     <= bbpa_pkg::CFG_BSL2_RST;
            for (int w = 0; w < NW; w++)
            begin
                words_reg[w] <= '0;
            end
            mapped_reg   <= '0;
            free_cnt_reg <= RESET_NBUF;
        end
        else if (cfg_wen)
        begin
            unique case (bbpa_pkg::reg_idx_t'(cfg_addr))
                bbpa_pkg::REG_POOL_ENABLED: enable_reg <= cfg_wdata[0];
                bbpa_pkg::REG_POOL_BASE:    base_reg   <= cfg_wdata;
                bbpa_pkg::REG_POOL_PAGES:   pages_reg  <= cfg_wdata[PAGES_W-1:0];
                bbpa_pkg::REG_BUF_SIZE_L2:  bsl2_reg   <= cfg_wdata[BSL2_W-1:0];
            endcase
            // any register write empties the pool
            for (int w = 0; w < NW; w++)
            begin
                words_reg[w] <= '0;
            end
            mapped_reg   <= '0;
            free_cnt_reg <= cfg_nbuf;
        end
        else
        begin
            unique case (cmd.op)
                bbpa_pkg::DP_ALLOC_SET:
                begin
                    if (alloc_ok)
                    begin
                        words_reg[widx_reg] <= rd_word | (WORD_W'(1) << zero_b);
                        free_cnt_reg        <= free_cnt_reg - NBUF_W'(1);
                    end
                end
                bbpa_pkg::DP_ALLOC_MAP:
                begin
                    if (ok_reg && alloc_page_ok)
                    begin
                        mapped_reg[alloc_page[PG_W-1:0]] <= 1'b1;
                    end
                end
                bbpa_pkg::DP_FREE_CHK:
                begin
                    if (free_ok)
                    begin
                        words_reg[rd_n[BIT_W-1:WB_W]] <=
                            rd_word & ~(WORD_W'(1) << rd_n[WB_W-1:0]);
                        free_cnt_reg <= free_cnt_reg + NBUF_W'(1);
                    end
                end
                bbpa_pkg::DP_TRIM_STEP:
                begin
                    if (trim_hit)
                    begin
                        mapped_reg[trim_page] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers and result
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            bbpa_pkg::DP_START:
            begin
                op_reg         <= bbpa_pkg::op_t'(in_opcode);
                addr_reg       <= in_address;
                res_addr_reg   <= '0;
                res_status_reg <= bbpa_pkg::ST_OK;
                freed_reg      <= '0;
                ok_reg         <= 1'b0;
            end
            bbpa_pkg::DP_DISABLED:
            begin
                res_status_reg <= bbpa_pkg::ST_DISABLED;
            end
            bbpa_pkg::DP_ALLOC_FIND:
            begin
                widx_reg  <= alloc_widx;
                found_reg <= alloc_found;
            end
            bbpa_pkg::DP_ALLOC_SET:
            begin
                ok_reg         <= alloc_ok;
                n_reg          <= alloc_n;
                res_status_reg <= alloc_ok ? bbpa_pkg::ST_OK : bbpa_pkg::ST_NO_BUF;
            end
            bbpa_pkg::DP_ALLOC_MAP:
            begin
                if (ok_reg)
                begin
                    res_addr_reg <= base_reg + alloc_off[ADDR_W-1:0];
                end
            end
            bbpa_pkg::DP_FREE_SUB:
            begin
                off_reg <= addr_reg - base_reg;
            end
            bbpa_pkg::DP_FREE_CHK:
            begin
                if (!free_ok)
                begin
                    res_status_reg <= bbpa_pkg::ST_BAD_ADDR;
                end
            end
            bbpa_pkg::DP_TRIM_INIT:
            begin
                cnt_reg   <= '0;
                clean_reg <= 1'b1;
            end
            bbpa_pkg::DP_TRIM_STEP:
            begin
                if (trim_valid)
                begin
                    cnt_reg <= cnt_inc;
                    // small buffers: a page group restarts clean after its last bit
                    if (!big_mode)
                    begin
                        clean_reg <= grp_end ? 1'b1 : clean_now;
                    end
                    if (trim_hit)
                    begin
                        freed_reg <= freed_reg + PCNT_W'(1);
                    end
                end
            end
            bbpa_pkg::DP_LOAD_OUT:
            begin
                out_tdata_reg <= {5'd0,
                                  bbpa_pkg::FREEBUF_W'(free_cnt_reg),
                                  (freed_reg != '0),
                                  bbpa_pkg::FREED_W'(freed_reg),
                                  res_status_reg,
                                  res_addr_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign stat.opcode    = op_reg;
    assign stat.enabled   = enable_reg;
    assign stat.trim_done = !trim_valid;
    assign out_tdata      = out_tdata_reg;

endmodule

`default_nettype wire

// ===== design/bbpa_ctrl.sv =====
`default_nettype none

module bbpa_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire bbpa_pkg::dp_status_t  stat,
    output bbpa_pkg::dp_cmd_t          cmd
);

    bbpa_pkg::state_t state_reg;
    bbpa_pkg::state_t state_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bbpa_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = bbpa_pkg::DP_NONE;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            bbpa_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = bbpa_pkg::DP_START;
                    state_next = bbpa_pkg::S_DECODE;
                end
            end
            bbpa_pkg::S_DECODE:
            begin
                priority if (stat.opcode != bbpa_pkg::OP_NONE && !stat.enabled)
                begin
                    cmd.op     = bbpa_pkg::DP_DISABLED;
                    state_next = bbpa_pkg::S_FINISH;
                end
                else
                begin
                    unique case (stat.opcode)
                        bbpa_pkg::OP_ALLOC:
                        begin
                            cmd.op     = bbpa_pkg::DP_ALLOC_FIND;
                            state_next = bbpa_pkg::S_ALLOC_SET;
                        end
                        bbpa_pkg::OP_FREE:
                        begin
                            cmd.op     = bbpa_pkg::DP_FREE_SUB;
                            state_next = bbpa_pkg::S_FREE_CHK;
                        end
                        bbpa_pkg::OP_TRIM:
                        begin
                            cmd.op     = bbpa_pkg::DP_TRIM_INIT;
                            state_next = bbpa_pkg::S_TRIM;
                        end
                        bbpa_pkg::OP_NONE:
                        begin
                            state_next = bbpa_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            bbpa_pkg::S_ALLOC_SET:
            begin
                cmd.op     = bbpa_pkg::DP_ALLOC_SET;
                state_next = bbpa_pkg::S_ALLOC_MAP;
            end
            bbpa_pkg::S_ALLOC_MAP:
            begin
                cmd.op     = bbpa_pkg::DP_ALLOC_MAP;
                state_next = bbpa_pkg::S_FINISH;
            end
            bbpa_pkg::S_FREE_CHK:
            begin
                cmd.op     = bbpa_pkg::DP_FREE_CHK;
                state_next = bbpa_pkg::S_FINISH;
            end
            bbpa_pkg::S_TRIM:
            begin
                if (stat.trim_done)
                begin
                    state_next = bbpa_pkg::S_FINISH;
                end
                else
                begin
                    cmd.op = bbpa_pkg::DP_TRIM_STEP;
                end
            end
            bbpa_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op        = bbpa_pkg::DP_LOAD_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = bbpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bbpa_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ===== design/bitmap_buffer_pool_allocator_unit.sv =====
// Fixed-size buffer pool allocator. Each input transaction (opcode on s_tuser,
// address on s_tdata) gives exactly one result transaction. The block takes one
// transaction at a time; a finished result sits in the output register, so the
// next transaction is accepted while it waits. An allocate runs decode, word
// search, bit set and page map; a free runs decode, offset and check; a disabled
// pool or unused opcode runs decode only; a trim runs decode and then a walk,
// one page per cycle over MAX_PAGES when a buffer is at least a page, else one
// bitmap bit per cycle over the current buffer count. The result is loaded once
// the output slot is free, and the next one is accepted in the cycle after.
// Allocation finds the lowest clear bit through per-word full flags and then a
// 16-bit search of the selected word. Any configuration write empties the pool
// in the same cycle.
`default_nettype none

module bitmap_buffer_pool_allocator_unit #(
    parameter int MAX_BUFFERS    = 256,
    parameter int MAX_PAGES      = 64,
    parameter int PAGE_SIZE_LOG2 = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_wen,
    input  wire logic [bbpa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bbpa_pkg::ADDR_W-1:0]         cfg_wdata,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [bbpa_pkg::ADDR_W-1:0]         s_tdata,   // buffer_address[31:0]
    input  wire logic [bbpa_pkg::OPCODE_W-1:0]       s_tuser,   // opcode[1:0]

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // address[31:0], status[33:32], freed_pages[40:34], trim_freed[41],
    // free_buffers[50:42], zero[55:51]
    output logic [bbpa_pkg::OUT_W-1:0]               m_tdata
);

    bbpa_pkg::dp_cmd_t    cmd;
    bbpa_pkg::dp_status_t stat;

    bbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbpa_datapath #(
        .MAX_BUFFERS    (MAX_BUFFERS),
        .MAX_PAGES      (MAX_PAGES),
        .PAGE_SIZE_LOG2 (PAGE_SIZE_LOG2)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_address (s_tdata),
        .in_opcode  (s_tuser),
        .cmd        (cmd),
        .stat       (stat),
        .out_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_BUFS  = 256;
    localparam int POOL_PGS   = 64;
    localparam int PG_SHIFT   = 12;
    localparam int RAND_ITEMS = 650;
    localparam int CALM_AFTER = 570;

    typedef struct packed {
        logic [4:0]                     pad;
        logic [bbpa_pkg::FREEBUF_W-1:0] free_buffers;
        logic                           trim_freed;
        logic [bbpa_pkg::FREED_W-1:0]   freed_pages;
        bbpa_pkg::status_t              status;
        logic [bbpa_pkg::ADDR_W-1:0]    address;
    } result_t;

    typedef struct {
        bit                 is_cfg;
        bbpa_pkg::reg_idx_t ridx;
        logic [31:0]        val;
        bbpa_pkg::op_t      op;
        logic [31:0]        addr;
        bit                 typed;
        result_t            want;
    } plan_row_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wen   = 1'b0;
    logic [bbpa_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [bbpa_pkg::ADDR_W-1:0]     cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [bbpa_pkg::ADDR_W-1:0]     s_tdata   = '0;
    logic [bbpa_pkg::OPCODE_W-1:0]   s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [bbpa_pkg::OUT_W-1:0]      m_tdata;

    bitmap_buffer_pool_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow of the pool
    bit                  pool_en   = 1'b0;
    logic [31:0]         pool_base = '0;
    logic [6:0]          pool_pgs  = 7'd64;
    logic [4:0]          buf_l2    = 5'd10;
    bit [POOL_BUFS-1:0]  used_map  = '0;
    bit [POOL_PGS-1:0]   mapped_pg = '0;
    int unsigned         free_cnt  = POOL_BUFS;

    result_t   pending[$];
    plan_row_t plan[$];
    int        errors   = 0;
    bit        hold_req = 1'b0;
    bit        calm     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned buf_count();
        longint unsigned bytes;
        longint unsigned n;
        bytes = longint'(pool_pgs > POOL_PGS ? POOL_PGS : pool_pgs) << PG_SHIFT;
        n = bytes >> buf_l2;
        return (n > POOL_BUFS) ? POOL_BUFS : int'(n);
    endfunction

    function automatic void apply_cfg(bbpa_pkg::reg_idx_t idx, logic [31:0] v);
        case (idx)
            bbpa_pkg::REG_POOL_ENABLED: pool_en = v[0];
            bbpa_pkg::REG_POOL_BASE:    pool_base = v;
            bbpa_pkg::REG_POOL_PAGES:   pool_pgs = v[6:0];
            bbpa_pkg::REG_BUF_SIZE_L2:  buf_l2 = v[4:0];
            default: ;
        endcase
        used_map  = '0;
        mapped_pg = '0;
        free_cnt  = buf_count();
    endfunction

    function automatic int unsigned trim_pages();
        int unsigned nb, freed, per, sh, n, k, m, pg;
        bit clear;
        nb = buf_count();
        freed = 0;
        if (buf_l2 >= PG_SHIFT)
        begin
            sh  = buf_l2 - PG_SHIFT;
            per = 1 << sh;
            for (n = 0; n < nb; n++)
            begin
                if (!used_map[n])
                begin
                    for (k = 0; k < per && (n << sh) + k < POOL_PGS; k++)
                    begin
                        pg = (n << sh) + k;
                        if (mapped_pg[pg])
                        begin
                            mapped_pg[pg] = 1'b0;
                            freed++;
                        end
                    end
                end
            end
        end
        else
        begin
            // small buffers: a page is free only if every buffer in it is
            per = 1 << (PG_SHIFT - buf_l2);
            m = 0;
            for (n = 0; n < nb; n += per)
            begin
                clear = 1'b1;
                for (k = 0; k < per && n + k < nb; k++)
                    if (used_map[n + k])
                        clear = 1'b0;
                if (clear && m < POOL_PGS && mapped_pg[m])
                begin
                    mapped_pg[m] = 1'b0;
                    freed++;
                end
                m++;
            end
        end
        return freed;
    endfunction

    function automatic result_t pool_step(bbpa_pkg::op_t op, logic [31:0] a);
        result_t         r;
        int unsigned     nb, idx, freed;
        longint unsigned off, mask, fidx;
        logic [31:0]     rel;
        r  = '0;
        nb = buf_count();
        if (op != bbpa_pkg::OP_NONE && !pool_en)
        begin
            r.status = bbpa_pkg::ST_DISABLED;
        end
        else
        begin
            case (op)
                bbpa_pkg::OP_ALLOC:
                begin
                    idx = 0;
                    while (idx < nb && used_map[idx])
                        idx++;
                    if (free_cnt == 0 || idx >= nb)
                    begin
                        r.status = bbpa_pkg::ST_NO_BUF;
                    end
                    else
                    begin
                        off = longint'(idx) << buf_l2;
                        used_map[idx] = 1'b1;
                        free_cnt--;
                        r.address = pool_base + off[31:0];
                        if ((off >> PG_SHIFT) < POOL_PGS)
                            mapped_pg[off >> PG_SHIFT] = 1'b1;
                    end
                end
                bbpa_pkg::OP_FREE:
                begin
                    rel  = a - pool_base;
                    mask = (64'd1 << buf_l2) - 64'd1;
                    fidx = longint'(rel) >> buf_l2;
                    if ((64'(rel) & mask) != 0 || fidx >= nb || !used_map[fidx])
                    begin
                        r.status = bbpa_pkg::ST_BAD_ADDR;
                    end
                    else
                    begin
                        used_map[fidx] = 1'b0;
                        free_cnt++;
                    end
                end
                bbpa_pkg::OP_TRIM:
                begin
                    freed = trim_pages();
                    r.freed_pages = freed[bbpa_pkg::FREED_W-1:0];
                    r.trim_freed  = (freed != 0);
                end
                default: ;
            endcase
        end
        r.free_buffers = free_cnt[bbpa_pkg::FREEBUF_W-1:0];
        return r;
    endfunction

    function automatic plan_row_t blank_row();
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.ridx   = bbpa_pkg::REG_POOL_ENABLED;
        row.val    = '0;
        row.op     = bbpa_pkg::OP_NONE;
        row.addr   = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(bbpa_pkg::reg_idx_t idx, logic [31:0] v);
        plan_row_t row;
        row = blank_row();
        row.is_cfg = 1'b1;
        row.ridx   = idx;
        row.val    = v;
        return row;
    endfunction

    function automatic plan_row_t op_row(bbpa_pkg::op_t op, logic [31:0] a,
                                         bit typed = 1'b0,
                                         logic [31:0] w_addr = '0,
                                         bbpa_pkg::status_t w_st = bbpa_pkg::ST_OK,
                                         int unsigned w_free = 0);
        plan_row_t row;
        row = blank_row();
        row.op    = op;
        row.addr  = a;
        row.typed = typed;
        row.want.address      = w_addr;
        row.want.status       = w_st;
        row.want.free_buffers = w_free[bbpa_pkg::FREEBUF_W-1:0];
        return row;
    endfunction

    task automatic send_op(bbpa_pkg::op_t op, logic [31:0] a, bit typed, result_t want);
        result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= a;
        do
            @(posedge clk);
        while (!s_tready);
        r = pool_step(op, a);
        pending.push_back(typed ? want : r);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // config may only change with nothing in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(bbpa_pkg::reg_idx_t idx, logic [31:0] v);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        apply_cfg(idx, v);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction: %h", m_tdata);
            end
            else
            begin
                want = pending.pop_front();
                if (got.address !== want.address || got.status !== want.status ||
                    got.freed_pages !== want.freed_pages ||
                    got.trim_freed !== want.trim_freed ||
                    got.free_buffers !== want.free_buffers)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp addr=%h st=%0d pg=%0d tf=%0b free=%0d",
                                 want.address, want.status, want.freed_pages,
                                 want.trim_freed, want.free_buffers,
                                 " got addr=%h st=%0d pg=%0d tf=%0b free=%0d",
                                 got.address, got.status, got.freed_pages,
                                 got.trim_freed, got.free_buffers);
                end
            end
        end
    end

    initial
    begin : stim
        int                 phase, n_items, a_pct, r, k, first, nregs, sent, i;
        int unsigned        nb;
        int unsigned        live[$];
        bbpa_pkg::op_t      op;
        logic [31:0]        a, v;
        bbpa_pkg::reg_idx_t ridx;

        // pool disabled out of reset
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0, 1, 32'h0,
                              bbpa_pkg::ST_DISABLED, 256));
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_FFFF, 1, 32'h0,
                              bbpa_pkg::ST_DISABLED, 256));
        plan.push_back(op_row(bbpa_pkg::OP_TRIM, 32'h0, 1, 32'h0,
                              bbpa_pkg::ST_DISABLED, 256));
        plan.push_back(op_row(bbpa_pkg::OP_NONE, 32'h0, 1, 32'h0,
                              bbpa_pkg::ST_OK, 256));
        plan.push_back(cfg_row(bbpa_pkg::REG_POOL_ENABLED, 32'd1));
        plan.push_back(cfg_row(bbpa_pkg::REG_POOL_BASE, 32'hFFFF_F000));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0, 1, 32'hFFFF_F000,
                              bbpa_pkg::ST_OK, 255));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0, 1, 32'hFFFF_F400,
                              bbpa_pkg::ST_OK, 254));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0));   // wraps past 2^32
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_F001));   // misaligned
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'h0000_1800));   // never allocated
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_EC00));   // below base
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_F400));
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_F400));   // double free
        plan.push_back(op_row(bbpa_pkg::OP_TRIM, 32'h0));
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_F000));
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_F800));
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_FC00));
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'h0000_0000));
        plan.push_back(op_row(bbpa_pkg::OP_TRIM, 32'h0));
        plan.push_back(op_row(bbpa_pkg::OP_NONE, 32'h5A5A_A5A5));
        // one buffer spanning the whole pool, page count saturated
        plan.push_back(cfg_row(bbpa_pkg::REG_POOL_PAGES, 32'd127));
        plan.push_back(cfg_row(bbpa_pkg::REG_BUF_SIZE_L2, 32'd18));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0, 1, 32'hFFFF_F000,
                              bbpa_pkg::ST_OK, 0));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0, 1, 32'h0,
                              bbpa_pkg::ST_NO_BUF, 0));
        plan.push_back(op_row(bbpa_pkg::OP_TRIM, 32'h0));
        plan.push_back(op_row(bbpa_pkg::OP_FREE, 32'hFFFF_F000));
        plan.push_back(op_row(bbpa_pkg::OP_TRIM, 32'h0));
        // empty pool
        plan.push_back(cfg_row(bbpa_pkg::REG_POOL_PAGES, 32'd0));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0, 1, 32'h0,
                              bbpa_pkg::ST_NO_BUF, 0));
        plan.push_back(op_row(bbpa_pkg::OP_TRIM, 32'h0));
        plan.push_back(cfg_row(bbpa_pkg::REG_POOL_BASE, 32'h0));
        plan.push_back(cfg_row(bbpa_pkg::REG_POOL_PAGES, 32'd64));
        plan.push_back(cfg_row(bbpa_pkg::REG_BUF_SIZE_L2, 32'd4));
        plan.push_back(op_row(bbpa_pkg::OP_ALLOC, 32'h0, 1, 32'h0,
                              bbpa_pkg::ST_OK, 255));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[j])
        begin
            if (plan[j].is_cfg)
            begin
                drain();
                write_reg(plan[j].ridx, plan[j].val);
                cfg_wen <= 1'b0;
            end
            else
            begin
                send_op(plan[j].op, plan[j].addr, plan[j].typed, plan[j].want);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            drain();
            nregs = (phase == 0) ? 4 : $urandom_range(1, 4);
            first = $urandom_range(0, 3);
            for (k = 0; k < nregs; k++)
            begin
                ridx = bbpa_pkg::reg_idx_t'((first + k) % 4);
                case (ridx)
                    bbpa_pkg::REG_POOL_ENABLED: v = 32'($urandom_range(0, 9) != 0);
                    bbpa_pkg::REG_POOL_BASE:
                    begin
                        v = $urandom();
                        if ($urandom_range(0, 3) != 0)
                            v[11:0] = '0;
                    end
                    bbpa_pkg::REG_POOL_PAGES:
                    begin
                        case ($urandom_range(0, 5))
                            0:       v = $urandom_range(0, 127);
                            1:       v = 32'd64;
                            default: v = $urandom_range(1, 16);
                        endcase
                    end
                    default:
                    begin
                        if ($urandom_range(0, 4) == 0)
                            v = $urandom_range(0, 31);
                        else
                            v = $urandom_range(4, 12);
                    end
                endcase
                write_reg(ridx, v);
            end
            cfg_wen <= 1'b0;

            if (phase == 3)
                hold_req = 1'b1;

            n_items = $urandom_range(15, 50);
            a_pct   = $urandom_range(30, 75);
            for (i = 0; i < n_items && sent < RAND_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                a = $urandom();
                if (r < a_pct)
                begin
                    op = bbpa_pkg::OP_ALLOC;
                end
                else if (r < 89)
                begin
                    op = bbpa_pkg::OP_FREE;
                    nb = buf_count();
                    k  = $urandom_range(0, 9);
                    if (k < 8)
                    begin
                        live.delete();
                        for (int b = 0; b < nb; b++)
                            if (used_map[b])
                                live.push_back(b);
                        if (live.size() != 0)
                            a = pool_base + 32'(longint'(live[$urandom_range(0,
                                    live.size() - 1)]) << buf_l2);
                    end
                    else if (k == 8)
                    begin
                        // aligned slot that may be free or just past the end, sometimes offset by one
                        a = pool_base + 32'(longint'($urandom_range(0, nb)) << buf_l2);
                        if ($urandom_range(0, 1) == 0)
                            a = a + 32'd1;
                    end
                end
                else if (r < 97)
                begin
                    op = bbpa_pkg::OP_TRIM;
                end
                else
                begin
                    op = bbpa_pkg::OP_NONE;
                end
                send_op(op, a, 1'b0, '0);
                sent++;
                if (sent >= CALM_AFTER)
                    calm = 1'b1;
            end
            phase++;
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/bbpa_pkg.sv
design/bbpa_datapath.sv
design/bbpa_ctrl.sv
design/bitmap_buffer_pool_allocator_unit.sv
sim/tb.sv
